@@ rtl/sgce_pkg.sv @@
// shared types and constants of the grid contact engine
`timescale 1ns / 1ps

package sgce_pkg;

  // fixed field widths
  localparam int SIDE_W     = 7;   // grid side register and wrapped coordinates
  localparam int MAG_W      = 16;  // magnitude of source plus offset
  localparam int DIV_BITS   = 4;   // remainder bits resolved per cycle
  localparam int DIV_CYCLES = MAG_W / DIV_BITS;
  localparam int DIV_CNT_W  = 2;
  localparam int CNT_W      = 14;  // internal population counters
  localparam int OUT_CNT_W  = 13;
  localparam logic [OUT_CNT_W-1:0] COUNT_MAX = 13'd8191;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd64;

  typedef enum logic [1:0] {
    FN_LOAD    = 2'd0,
    FN_SEED    = 2'd1,
    FN_CONTACT = 2'd2,
    FN_TICK    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_SUS = 2'd0,
    ST_EXP = 2'd1,
    ST_INF = 2'd2,
    ST_REM = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } fr_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_RMW,
    BK_SWEEP,
    BK_SWEEP_LAST,
    BK_TICK_DONE
  } bk_state_t;

  // request payload
  typedef struct packed {
    func_t              func;
    logic [5:0]         row;
    logic [5:0]         col;
    logic [7:0]         incubation_days;
    logic [7:0]         recovery_days;
    logic signed [15:0] offset_row;
    logic signed [15:0] offset_col;
  } req_t;

  // result payload
  typedef struct packed {
    logic [5:0]           target_row;
    logic [5:0]           target_col;
    logic                 newly_exposed;
    logic [OUT_CNT_W-1:0] exposed_count;
    logic [OUT_CNT_W-1:0] infectious_count;
    logic [OUT_CNT_W-1:0] removed_today;
    logic [OUT_CNT_W-1:0] sick_count;
  } res_t;

  // decoded command from front to back
  typedef struct packed {
    func_t             func;
    logic              in_grid;
    logic [SIDE_W-1:0] row;
    logic [SIDE_W-1:0] col;
    logic [7:0]        inc;
    logic [7:0]        rec;
  } cmd_t;

  // one stored grid entry
  typedef struct packed {
    status_t    status;
    logic [7:0] inc;
    logic [7:0] rec;
  } cell_t;

endpackage

@@ rtl/sgce_front.sv @@
// front end: takes requests, checks bounds and wraps contact targets
`timescale 1ns / 1ps

module sgce_front import sgce_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIDE_W-1:0] side,
  input  logic              clearing,
  input  req_t              req,
  input  logic              req_valid,
  output logic              req_ready,
  output cmd_t              cmd,
  output logic              cmd_valid,
  input  logic              cmd_ready
);

  fr_state_t st, st_next;
  cmd_t cur, cur_next;
  logic neg_r, neg_c, neg_r_next, neg_c_next;
  logic [MAG_W-1:0] mag_r, mag_c, mag_r_next, mag_c_next;
  logic [SIDE_W-1:0] rem_r, rem_c, rem_r_next, rem_c_next;
  logic [DIV_CNT_W-1:0] step, step_next;

  logic accept;
  logic signed [MAG_W:0] sum_r, sum_c, abs_r, abs_c;

  // one restoring remainder step
  function automatic logic [SIDE_W-1:0] rem_step(input logic [SIDE_W-1:0] rem,
                                                 input logic b,
                                                 input logic [SIDE_W-1:0] s);
    logic [SIDE_W:0] t;
    t = {rem, b};
    if (t >= {1'b0, s}) t = t - {1'b0, s};
    return t[SIDE_W-1:0];
  endfunction

  // fold a truncated remainder back into 0..side-1
  function automatic logic [SIDE_W-1:0] fix_rem(input logic [SIDE_W-1:0] rem,
                                                input logic neg,
                                                input logic [SIDE_W-1:0] s);
    return (neg && rem != '0) ? s - rem : rem;
  endfunction

  assign req_ready = !clearing && (st == FR_IDLE || (st == FR_PUSH && cmd_ready));
  assign accept    = req_valid && req_ready;

  // signed source plus offset and its magnitude
  always_comb begin
    sum_r = $signed({{(MAG_W-5){1'b0}}, req.row}) + $signed({req.offset_row[15], req.offset_row});
    sum_c = $signed({{(MAG_W-5){1'b0}}, req.col}) + $signed({req.offset_col[15], req.offset_col});
    abs_r = sum_r[MAG_W] ? -sum_r : sum_r;
    abs_c = sum_c[MAG_W] ? -sum_c : sum_c;
  end

  // command toward the queue
  always_comb begin
    cmd = cur;
    if (cur.func == FN_CONTACT) begin
      cmd.row = fix_rem(rem_r, neg_r, side);
      cmd.col = fix_rem(rem_c, neg_c, side);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= FR_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    neg_r <= neg_r_next;
    neg_c <= neg_c_next;
    mag_r <= mag_r_next;
    mag_c <= mag_c_next;
    rem_r <= rem_r_next;
    rem_c <= rem_c_next;
    step  <= step_next;
  end

  // next state, remainder lanes and request capture
  always_comb begin
    st_next    = st;
    cur_next   = cur;
    neg_r_next = neg_r;
    neg_c_next = neg_c;
    mag_r_next = mag_r;
    mag_c_next = mag_c;
    rem_r_next = rem_r;
    rem_c_next = rem_c;
    step_next  = step;
    cmd_valid  = 1'b0;

    case (st)
      FR_DIV: begin
        for (int i = 0; i < DIV_BITS; i++) begin
          rem_r_next = rem_step(rem_r_next, mag_r[MAG_W-1-i], side);
          rem_c_next = rem_step(rem_c_next, mag_c[MAG_W-1-i], side);
        end
        mag_r_next = mag_r << DIV_BITS;
        mag_c_next = mag_c << DIV_BITS;
        step_next  = step + 1'b1;
        if (step == DIV_CNT_W'(DIV_CYCLES - 1)) st_next = FR_PUSH;
      end
      FR_PUSH: begin
        cmd_valid = 1'b1;
        if (cmd_ready) st_next = FR_IDLE;
      end
      default: ;
    endcase

    // capture a new request, also in the cycle the previous one is pushed
    if (accept) begin
      cur_next.func    = req.func;
      cur_next.in_grid = ({1'b0, req.row} < side) && ({1'b0, req.col} < side);
      cur_next.row     = {1'b0, req.row};
      cur_next.col     = {1'b0, req.col};
      cur_next.inc     = req.incubation_days;
      cur_next.rec     = req.recovery_days;
      neg_r_next       = sum_r[MAG_W];
      neg_c_next       = sum_c[MAG_W];
      mag_r_next       = abs_r[MAG_W-1:0];
      mag_c_next       = abs_c[MAG_W-1:0];
      rem_r_next       = '0;
      rem_c_next       = '0;
      step_next        = '0;
      st_next          = (req.func == FN_CONTACT) ? FR_DIV : FR_PUSH;
    end
  end

endmodule

@@ rtl/sgce_fifo.sv @@
// two entry command queue between front and back
`timescale 1ns / 1ps

module sgce_fifo import sgce_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_data,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_data,
  output logic pop_valid,
  input  logic pop_ready
);

  cmd_t slots [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] cnt;
  logic do_push, do_pop;

  assign push_ready = (cnt != 2'd2);
  assign pop_valid  = (cnt != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) cnt <= cnt + 2'd1;
      else if (do_pop && !do_push) cnt <= cnt - 2'd1;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue fill level out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd0 || cnt == 2'd2) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with fill level");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 && !pop_ready) |=> cnt == 2'd2)
    else $error("full queue changed without a pop");
`endif

endmodule

@@ rtl/sgce_back.sv @@
// back end: grid store, contact and seed updates, day tick sweep
`timescale 1ns / 1ps

module sgce_back import sgce_pkg::*; #(
  parameter int GRID_SIDE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIDE_W-1:0] side,
  input  cmd_t              cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  output res_t              res,
  output logic              res_valid,
  input  logic              res_ready,
  output logic              clearing
);

  localparam int CW    = $clog2(GRID_SIDE);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;

  cell_t mem [DEPTH];
  cell_t rdata, wr_data, upd;
  logic [AW-1:0] rd_addr, wr_addr;
  logic rd_en, mem_we;

  bk_state_t state, state_next;
  logic [AW-1:0] clr_addr, clr_addr_next;
  logic [SIDE_W-1:0] sw_r, sw_c, sw_r_next, sw_c_next;
  logic pend_valid, pend_valid_next;
  logic [AW-1:0] pend_addr, pend_addr_next;
  cmd_t cur, cur_next;
  logic [CNT_W-1:0] ne, ni, nr, ne_next, ni_next, nr_next;
  logic res_valid_next;
  res_t res_next;
  logic [SIDE_W-1:0] side_last;

  // coordinate to memory address, row above column
  function automatic logic [AW-1:0] addr_of(input logic [SIDE_W-1:0] r,
                                            input logic [SIDE_W-1:0] c);
    logic [CW+SIDE_W-1:0] er, ec;
    er = {{CW{1'b0}}, r};
    ec = {{CW{1'b0}}, c};
    return {er[CW-1:0], ec[CW-1:0]};
  endfunction

  // one day of incubation then recovery
  function automatic cell_t tick_cell(input cell_t cin);
    cell_t c;
    c = cin;
    if (c.status == ST_EXP) begin
      if (c.inc == 8'd0) c.status = ST_INF;
      else c.inc = c.inc - 8'd1;
    end
    if (c.status == ST_INF) begin
      if (c.rec == 8'd0) c.status = ST_REM;
      else c.rec = c.rec - 8'd1;
    end
    return c;
  endfunction

  function automatic logic [OUT_CNT_W-1:0] sat(input logic [CNT_W:0] v);
    return (v > {{(CNT_W+1-OUT_CNT_W){1'b0}}, COUNT_MAX}) ? COUNT_MAX : v[OUT_CNT_W-1:0];
  endfunction

  assign clearing  = (state == BK_CLEAR);
  assign side_last = side - 7'd1;
  assign upd       = tick_cell(rdata);

  // grid store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BK_CLEAR;
      clr_addr   <= '0;
      pend_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      pend_valid <= pend_valid_next;
      res_valid  <= res_valid_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    sw_r      <= sw_r_next;
    sw_c      <= sw_c_next;
    pend_addr <= pend_addr_next;
    cur       <= cur_next;
    ne        <= ne_next;
    ni        <= ni_next;
    nr        <= nr_next;
    res       <= res_next;
  end

  // sequencer for clear, commands and sweep
  always_comb begin
    state_next      = state;
    clr_addr_next   = clr_addr;
    sw_r_next       = sw_r;
    sw_c_next       = sw_c;
    pend_valid_next = pend_valid;
    pend_addr_next  = pend_addr;
    cur_next        = cur;
    ne_next         = ne;
    ni_next         = ni;
    nr_next         = nr;
    res_valid_next  = res_valid && !res_ready;
    res_next        = res;
    mem_we          = 1'b0;
    wr_addr         = pend_addr;
    wr_data         = rdata;
    rd_en           = 1'b0;
    rd_addr         = addr_of(sw_r, sw_c);
    cmd_pop         = 1'b0;

    case (state)
      BK_CLEAR: begin
        mem_we        = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (&clr_addr) state_next = BK_IDLE;
      end
      BK_IDLE: begin
        if (cmd_valid && !res_valid) begin
          cmd_pop  = 1'b1;
          cur_next = cmd;
          case (cmd.func)
            FN_LOAD: begin
              mem_we         = cmd.in_grid;
              wr_addr        = addr_of(cmd.row, cmd.col);
              wr_data        = '{status: ST_SUS, inc: cmd.inc, rec: cmd.rec};
              res_next       = '0;
              res_valid_next = 1'b1;
            end
            FN_SEED, FN_CONTACT: begin
              rd_en      = 1'b1;
              rd_addr    = addr_of(cmd.row, cmd.col);
              state_next = BK_RMW;
            end
            FN_TICK: begin
              ne_next         = '0;
              ni_next         = '0;
              nr_next         = '0;
              sw_r_next       = '0;
              sw_c_next       = '0;
              pend_valid_next = 1'b0;
              state_next      = BK_SWEEP;
            end
            default: ;
          endcase
        end
      end
      BK_RMW: begin
        wr_addr        = addr_of(cur.row, cur.col);
        res_next       = '0;
        res_valid_next = 1'b1;
        state_next     = BK_IDLE;
        if (cur.func == FN_SEED) begin
          mem_we         = cur.in_grid;
          wr_data.status = ST_INF;
        end else begin
          res_next.target_row = cur.row[5:0];
          res_next.target_col = cur.col[5:0];
          if (rdata.status == ST_SUS) begin
            mem_we                 = 1'b1;
            wr_data.status         = ST_EXP;
            res_next.newly_exposed = 1'b1;
          end
        end
      end
      BK_SWEEP: begin
        // read this cell while writing back the previous one
        rd_en           = 1'b1;
        pend_addr_next  = rd_addr;
        pend_valid_next = 1'b1;
        if (pend_valid) begin
          mem_we  = 1'b1;
          wr_data = upd;
          ne_next = ne + CNT_W'(upd.status == ST_EXP);
          ni_next = ni + CNT_W'(upd.status == ST_INF);
          nr_next = nr + CNT_W'(upd.status == ST_REM && rdata.status != ST_REM);
        end
        if (sw_c == side_last) begin
          sw_c_next = '0;
          if (sw_r == side_last) state_next = BK_SWEEP_LAST;
          else sw_r_next = sw_r + 1'b1;
        end else begin
          sw_c_next = sw_c + 1'b1;
        end
      end
      BK_SWEEP_LAST: begin
        mem_we     = 1'b1;
        wr_data    = upd;
        ne_next    = ne + CNT_W'(upd.status == ST_EXP);
        ni_next    = ni + CNT_W'(upd.status == ST_INF);
        nr_next    = nr + CNT_W'(upd.status == ST_REM && rdata.status != ST_REM);
        state_next = BK_TICK_DONE;
      end
      BK_TICK_DONE: begin
        res_next                  = '0;
        res_next.exposed_count    = sat({1'b0, ne});
        res_next.infectious_count = sat({1'b0, ni});
        res_next.removed_today    = sat({1'b0, nr});
        res_next.sick_count       = sat({1'b0, ne} + {1'b0, ni});
        res_valid_next            = 1'b1;
        state_next                = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == BK_CLEAR |-> !res_valid && !cmd_pop)
    else $error("activity during clearing pass");
  a_pop_free: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !res_valid && state == BK_IDLE)
    else $error("command taken while a result is pending");
  a_rw_apart: assert property (@(posedge clk) disable iff (rst)
    (mem_we && rd_en) |-> wr_addr != rd_addr)
    else $error("grid read and write collide");
`endif

endmodule

@@ rtl/seir_grid_contact_engine.sv @@
// top level of the grid contact engine
//
//   channel   signals                     direction  carries
//   req       req, req_valid, req_ready   in         load, seed, contact or day tick
//   res       res, res_valid, res_ready   out        one result per request
//   cfg       cfg_we, cfg_wdata           in         grid side, write only
//
// load writes the grid and gives its result directly; seed and contact read-modify-write
//   the grid memory; contact first runs the remainder lanes (4 bits a cycle)
// day tick: one cell per cycle, reading one cell while writing back the previous one
// after reset a clearing pass writes all 2^(2*ceil(log2 GRID_SIDE)) entries (4096 at 64)
//   and no request is taken until it ends
// the front keeps taking requests while a result waits, until the command queue is full
`timescale 1ns / 1ps

module seir_grid_contact_engine import sgce_pkg::*; #(
  parameter int GRID_SIDE = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  req_t              req,
  input  logic              req_valid,
  output logic              req_ready,
  output res_t              res,
  output logic              res_valid,
  input  logic              res_ready,
  input  logic              cfg_we,
  input  logic [SIDE_W-1:0] cfg_wdata
);

  localparam int SIDE_CAP = (GRID_SIDE > 127) ? 127 : GRID_SIDE;
  localparam logic [SIDE_W-1:0] SIDE_MAX = SIDE_CAP[SIDE_W-1:0];

  logic [SIDE_W-1:0] grid_side, side;
  logic clearing;
  cmd_t f_cmd, q_cmd;
  logic f_valid, f_ready, q_valid, q_pop;

  // grid side register
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_side <= SIDE_RESET;
    end else if (cfg_we) begin
      grid_side <= cfg_wdata;
    end
  end

  // side in use, clamped to 1..GRID_SIDE and at most 127
  always_comb begin
    if (grid_side == '0) side = 7'd1;
    else if (grid_side > SIDE_MAX) side = SIDE_MAX;
    else side = grid_side;
  end

  sgce_front u_front (
    .clk       (clk),
    .rst       (rst),
    .side      (side),
    .clearing  (clearing),
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  sgce_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_data  (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_data   (q_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop)
  );

  sgce_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .side      (side),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .res       (res),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .clearing  (clearing)
  );

endmodule
